// ----- design/bpc_pkg.sv -----
// Shared types and constants for the button press classifier.
// Holds payload words, state and configuration records, and event codes.
// No dependencies.
package bpc_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned CfgIdxW   = 2;

  // event codes
  localparam logic [2:0] EvNone     = 3'd0;
  localparam logic [2:0] EvPress    = 3'd1;
  localparam logic [2:0] EvClick    = 3'd2;
  localparam logic [2:0] EvLong     = 3'd3;
  localparam logic [2:0] EvExtended = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDebounce    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLong        = 2'd1;
  localparam logic [CfgIdxW-1:0] RegExtended    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMinInterval = 2'd3;

  // configuration reset values
  localparam logic [CfgWidth-1:0] DebounceRst    = 16'd50;
  localparam logic [CfgWidth-1:0] LongRst        = 16'd1000;
  localparam logic [CfgWidth-1:0] ExtendedRst    = 16'd5000;
  localparam logic [CfgWidth-1:0] MinIntervalRst = 16'd100;

  typedef struct packed {
    logic raw_level;
    logic clear_session;
  } in_word_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       is_pressed;
  } out_word_t;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_ms;
    logic [CfgWidth-1:0] long_ms;
    logic [CfgWidth-1:0] extended_ms;
    logic [CfgWidth-1:0] min_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeWidth-1:0] now_ms;
    logic [TimeWidth-1:0] last_change_ms;
    logic [TimeWidth-1:0] press_start_ms;
    logic [TimeWidth-1:0] release_ms;
    logic                 debounced_level;
    logic                 session_active;
    logic                 long_fired;
    logic                 extended_fired;
    logic                 click_fired;
  } state_t;

endpackage

// ----- design/bpc_step.sv -----
// Per-tick next-state and event logic of the button press classifier.
// Purely combinational; depends on bpc_pkg.
module bpc_step
  import bpc_pkg::*;
(
  input  state_t    state_i,
  input  cfg_t      cfg_i,
  input  in_word_t  word_i,
  output state_t    state_o,
  output out_word_t word_o
);

  always_comb begin
    state_t               s;
    logic [2:0]           ev;
    logic [TimeWidth-1:0] now;
    logic [TimeWidth-1:0] since_change;
    logic [TimeWidth-1:0] since_release;
    logic [TimeWidth-1:0] held;
    logic                 change;

    s   = state_i;
    ev  = EvNone;
    now = state_i.now_ms + TimeWidth'(1);
    s.now_ms = now;

    // clear acts before the level is looked at
    if (word_i.clear_session) begin
      s.session_active = 1'b0;
      s.long_fired     = 1'b0;
      s.extended_fired = 1'b0;
      s.click_fired    = 1'b0;
      s.press_start_ms = '0;
    end

    since_change  = now - s.last_change_ms;
    since_release = now - s.release_ms;
    change = (since_change > TimeWidth'(cfg_i.debounce_ms))
             && (word_i.raw_level != s.debounced_level);

    held = now - s.press_start_ms;
    if (change) begin
      s.debounced_level = word_i.raw_level;
      s.last_change_ms  = now;
      if (word_i.raw_level) begin
        if (since_release >= TimeWidth'(cfg_i.min_interval_ms)) begin
          s.press_start_ms = now;
          s.session_active = 1'b1;
          s.long_fired     = 1'b0;
          s.extended_fired = 1'b0;
          s.click_fired    = 1'b0;
          ev               = EvPress;
        end
      end else begin
        s.release_ms = now;
        if (s.session_active && !s.long_fired && !s.extended_fired && !s.click_fired
            && held >= TimeWidth'(cfg_i.debounce_ms)
            && held < TimeWidth'(cfg_i.long_ms)) begin
          s.click_fired = 1'b1;
          ev            = EvClick;
        end
        s.long_fired     = 1'b0;
        s.extended_fired = 1'b0;
        s.session_active = 1'b0;
      end
    end

    // hold monitoring; press start is unchanged when no event fired above
    if (ev == EvNone && s.debounced_level && s.session_active) begin
      if (!s.extended_fired && held >= TimeWidth'(cfg_i.extended_ms)) begin
        s.extended_fired = 1'b1;
        s.long_fired     = 1'b1;
        ev               = EvExtended;
      end else if (!s.long_fired && !s.extended_fired
                   && held >= TimeWidth'(cfg_i.long_ms)) begin
        s.long_fired = 1'b1;
        ev           = EvLong;
      end
    end

    state_o           = s;
    word_o.event_code = ev;
    word_o.is_pressed = s.debounced_level;
  end

endmodule

// ----- design/button_press_classifier_core.sv -----
// Top level of the button press classifier: debounce, sessions and events.
// Depends on bpc_pkg and bpc_step.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_word_i) carries one word per
//   millisecond tick: the raw button level and a clear-session strobe.
//   Output channel (out_valid_o / out_ready_i / out_word_o) returns exactly
//   one word per accepted tick: the event code (none, press, click, long,
//   extended) and the debounced level after that tick.
//   Configuration port (cfg_we_i / cfg_idx_i / cfg_data_i) writes one of
//   debounce, long, extended and minimum-interval times; write only while
//   the block is idle.
// Timing:
//   A word accepted at one edge shows up at out_word_o right after that edge.
//   Throughput is one word per cycle unless out_ready_i stalls: the whole
//   tick update is one pass of compares and 32-bit subtractions in bpc_step
//   between the state registers and the output register.
// Reset:
//   Clears all timers and flags, sets the debounced level to released, loads
//   the default times and empties the output register.
// Stall:
//   When the receiver holds out_ready_i low with a word pending, in_ready_o
//   drops, the state holds and no tick is taken until the word leaves.
module button_press_classifier_core
  import bpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o
);

  cfg_t      cfg_q;
  state_t    state_q;
  state_t    state_d;
  out_word_t result_d;
  out_word_t out_word_q;
  logic      out_valid_q;
  logic      accept;

  // take a new tick whenever the output register is empty or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= DebounceRst;
      cfg_q.long_ms         <= LongRst;
      cfg_q.extended_ms     <= ExtendedRst;
      cfg_q.min_interval_ms <= MinIntervalRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDebounce:    cfg_q.debounce_ms     <= cfg_data_i;
        RegLong:        cfg_q.long_ms         <= cfg_data_i;
        RegExtended:    cfg_q.extended_ms     <= cfg_data_i;
        RegMinInterval: cfg_q.min_interval_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpc_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .word_i  (in_word_i),
    .state_o (state_d),
    .word_o  (result_d)
  );

  // advance the classifier state once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // output register: load on accept, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
